@@ rtl/assert_macros.svh @@
// Assertion macros shared by the flood counter RTL.
// Included by the controller and datapath; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/dafc_pkg.sv @@
// Shared types and constants for the destination address flood counter.
// No dependencies; imported by the controller, datapath and top level.
package dafc_pkg;

    localparam int ADDR_W = 32;
    localparam int CNT_W  = 32;
    localparam int KIND_W = 2;
    localparam int PADDR_W = 2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_FLAGGED  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd2;

    // Input operations
    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // Register map
    localparam logic [PADDR_W-1:0] REG_PACKET_LIMIT = 2'd0;
    localparam logic [CNT_W-1:0]   PACKET_LIMIT_RST = 32'd1000;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  cnt;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming address
        logic compare;   // register the address match vector
        logic look;      // latch the hit index
        logic append;    // write a new entry at the fill point
        logic update;    // write back the incremented count
        logic walk;      // read port follows the walk index
        logic step;      // advance the walk index
        logic hold_pend; // park the current entry as pending result
        logic emit_ovf;  // load an overflow result
        logic emit_pend; // load the pending entry, not last
        logic emit_end;  // load the closing result of a report
        logic clear;     // drop all entries, reset the walk
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic hit;
        logic full;      // append now would fill the table
        logic walk_done;
        logic flagged;
        logic pend_v;
        logic out_free;
    } t_dp_sts;

endpackage

@@ rtl/dest_address_flood_counter_unit.sv @@
// Destination address flood counter, top level.
// Input channel i_in_valid/o_in_ready carries i_op and i_dest_addr; result
// channel o_out_valid/i_out_ready carries o_kind, o_flagged_addr,
// o_flagged_count and o_last. packet_limit sits at APB byte address 0.
// A packet transaction passes through compare and lookup and then, on a hit,
// a read-modify-write of the count in the entry memory, or on a miss an
// append, before o_in_ready returns; an overflowing append adds a state that
// waits for the output register. A report reads the used entries one after
// another (memory read, then the limit compare), as the walk goes through the
// single read port.
// The first result of a report leaves once the next flagged entry is found,
// since the last marker is only known then.
// Reset empties the table (fill count to zero) and loads packet_limit with
// 1000; the entry stores themselves are not cleared and need no sweep.
// A stalled receiver only holds the output register: packet lookups carry
// on, and a report or overflow waits until the register frees up.
// Depends on dafc_pkg, dafc_ctrl and dafc_dp.

module dest_address_flood_counter_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item input
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_op,
    input  logic [dafc_pkg::ADDR_W-1:0]    i_dest_addr,
    // result output
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [dafc_pkg::KIND_W-1:0]    o_kind,
    output logic [dafc_pkg::ADDR_W-1:0]    o_flagged_addr,
    output logic [dafc_pkg::CNT_W-1:0]     o_flagged_count,
    output logic                           o_last,
    // APB register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dafc_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import dafc_pkg::*;

    logic [CNT_W-1:0] r_packet_limit;
    t_dp_cmd          dp_cmd;
    t_dp_sts          dp_sts;

    // Register port: zero wait states, write on the access phase
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_limit <= PACKET_LIMIT_RST;
        end else if (psel && penable && pwrite && pready && paddr == REG_PACKET_LIMIT) begin
            r_packet_limit <= pwdata;
        end
    end

    assign prdata = (paddr == REG_PACKET_LIMIT) ? r_packet_limit : '0;

    dafc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_sts      (dp_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (dp_cmd)
    );

    dafc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dest_addr     (i_dest_addr),
        .i_packet_limit  (r_packet_limit),
        .i_out_ready     (i_out_ready),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .o_out_valid     (o_out_valid),
        .o_kind          (o_kind),
        .o_flagged_addr  (o_flagged_addr),
        .o_flagged_count (o_flagged_count),
        .o_last          (o_last)
    );

endmodule

@@ rtl/dafc_dp.sv @@
// Datapath of the flood counter: address CAM, entry memory, walk and result register.
// Depends on dafc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dafc_dp #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [dafc_pkg::ADDR_W-1:0]   i_dest_addr,
    input  logic [dafc_pkg::CNT_W-1:0]    i_packet_limit,
    input  logic                          i_out_ready,
    input  dafc_pkg::t_dp_cmd             i_cmd,
    output dafc_pkg::t_dp_sts             o_sts,
    output logic                          o_out_valid,
    output logic [dafc_pkg::KIND_W-1:0]   o_kind,
    output logic [dafc_pkg::ADDR_W-1:0]   o_flagged_addr,
    output logic [dafc_pkg::CNT_W-1:0]    o_flagged_count,
    output logic                          o_last
);
    import dafc_pkg::*;

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int USED_W = $clog2(TABLE_DEPTH + 1);

    logic [ADDR_W-1:0]      r_addr;
    logic [ADDR_W-1:0]      r_cam [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_match;
    logic [USED_W-1:0]      r_used;
    logic [USED_W-1:0]      r_idx;
    logic [IDX_W-1:0]       r_wr_idx;
    t_entry                 r_mem [TABLE_DEPTH];
    t_entry                 r_rd_data;
    t_entry                 r_pend;
    logic                   r_pend_v;

    logic                   r_out_valid;
    logic [KIND_W-1:0]      r_kind;
    logic [ADDR_W-1:0]      r_faddr;
    logic [CNT_W-1:0]       r_fcnt;
    logic                   r_last;

    logic [TABLE_DEPTH-1:0] match;
    logic [IDX_W-1:0]       hit_idx;
    logic [IDX_W-1:0]       rd_idx;
    logic [IDX_W-1:0]       wr_idx;
    logic                   mem_we;
    t_entry                 wr_data;
    logic [CNT_W-1:0]       cnt_inc;
    logic                   full;
    logic                   out_free;

    // Parallel compare against used entries
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            match[i] = (USED_W'(i) < r_used) && (r_cam[i] == r_addr);
        end
    end

    // Entries are unique, so OR-ing the indices gives the hit position
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (r_match[i]) begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    assign full     = (r_used == USED_W'(TABLE_DEPTH - 1));
    assign out_free = !r_out_valid || i_out_ready;
    assign cnt_inc  = (&r_rd_data.cnt) ? r_rd_data.cnt : r_rd_data.cnt + CNT_W'(1);
    assign rd_idx   = i_cmd.walk ? r_idx[IDX_W-1:0] : hit_idx;
    assign mem_we   = i_cmd.append || i_cmd.update;
    assign wr_idx   = i_cmd.append ? r_used[IDX_W-1:0] : r_wr_idx;

    always_comb begin
        if (i_cmd.append) begin
            wr_data.addr = r_addr;
            wr_data.cnt  = CNT_W'(1);
        end else begin
            wr_data.addr = r_rd_data.addr;
            wr_data.cnt  = cnt_inc;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_idx] <= wr_data;
        end
        r_rd_data <= r_mem[rd_idx];
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr <= i_dest_addr;
        end
        if (i_cmd.compare) begin
            r_match <= match;
        end
        if (i_cmd.look) begin
            r_wr_idx <= hit_idx;
        end
        if (i_cmd.append) begin
            r_cam[r_used[IDX_W-1:0]] <= r_addr;
        end
        if (i_cmd.hold_pend) begin
            r_pend <= r_rd_data;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_idx    <= '0;
            r_pend_v <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_used   <= '0;
                r_idx    <= '0;
                r_pend_v <= 1'b0;
            end else begin
                if (i_cmd.append) begin
                    r_used <= full ? '0 : r_used + USED_W'(1);
                end
                if (i_cmd.step) begin
                    r_idx <= r_idx + USED_W'(1);
                end
                if (i_cmd.hold_pend) begin
                    r_pend_v <= 1'b1;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_ovf || i_cmd.emit_pend || i_cmd.emit_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ovf) begin
            r_kind  <= KIND_OVERFLOW;
            r_faddr <= '0;
            r_fcnt  <= '0;
            r_last  <= 1'b1;
        end else if (i_cmd.emit_pend) begin
            r_kind  <= KIND_FLAGGED;
            r_faddr <= r_pend.addr;
            r_fcnt  <= r_pend.cnt;
            r_last  <= 1'b0;
        end else if (i_cmd.emit_end) begin
            r_kind  <= r_pend_v ? KIND_FLAGGED : KIND_NONE;
            r_faddr <= r_pend_v ? r_pend.addr : '0;
            r_fcnt  <= r_pend_v ? r_pend.cnt : '0;
            r_last  <= 1'b1;
        end
    end

    assign o_sts.hit       = |r_match;
    assign o_sts.full      = full;
    assign o_sts.walk_done = (r_idx == r_used);
    assign o_sts.flagged   = (r_rd_data.cnt > i_packet_limit);
    assign o_sts.pend_v    = r_pend_v;
    assign o_sts.out_free  = out_free;

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_flagged_addr  = r_faddr;
    assign o_flagged_count = r_fcnt;
    assign o_last          = r_last;

    `ASSERT_ALWAYS(a_used_below_depth, i_clk, i_rst_n, r_used < USED_W'(TABLE_DEPTH), "fill count reached table depth")
    `ASSERT_SAME(a_single_hit, i_clk, i_rst_n, i_cmd.look, $onehot0(r_match), "address held in more than one entry")
    `ASSERT_NEXT(a_end_drops_pend, i_clk, i_rst_n, i_cmd.emit_end, !r_pend_v && r_used == '0, "report end left entries behind")

endmodule

@@ rtl/dafc_ctrl.sv @@
// Sequencer of the flood counter: packet lookup/update and report walk.
// Depends on dafc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dafc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_op,
    input  dafc_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output dafc_pkg::t_dp_cmd o_cmd
);
    import dafc_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_CMP     = 8'b0000_0010,
        S_LOOK    = 8'b0000_0100,
        S_UPD     = 8'b0000_1000,
        S_OVF     = 8'b0001_0000,
        S_RPT_RD  = 8'b0010_0000,
        S_RPT_CHK = 8'b0100_0000,
        S_RPT_END = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_op == OP_REPORT) ? S_RPT_RD : S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state = S_LOOK;
            end
            S_LOOK: begin
                if (i_sts.hit) begin
                    o_cmd.look = 1'b1;
                    n_state = S_UPD;
                end else begin
                    o_cmd.append = 1'b1;
                    n_state = i_sts.full ? S_OVF : S_IDLE;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = S_IDLE;
            end
            S_OVF: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_ovf = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RPT_RD: begin
                o_cmd.walk = 1'b1;
                n_state = i_sts.walk_done ? S_RPT_END : S_RPT_CHK;
            end
            S_RPT_CHK: begin
                o_cmd.walk = 1'b1;
                if (!i_sts.flagged) begin
                    o_cmd.step = 1'b1;
                    n_state = S_RPT_RD;
                end else if (!i_sts.pend_v) begin
                    o_cmd.hold_pend = 1'b1;
                    o_cmd.step      = 1'b1;
                    n_state = S_RPT_RD;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_pend = 1'b1;
                    o_cmd.hold_pend = 1'b1;
                    o_cmd.step      = 1'b1;
                    n_state = S_RPT_RD;
                end
            end
            S_RPT_END: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_end = 1'b1;
                    o_cmd.clear    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    `ASSERT_SAME(a_upd_after_hit, i_clk, i_rst_n, r_state == S_UPD, $past(r_state) == S_LOOK && $past(i_sts.hit), "count update without a hit")
    `ASSERT_NEXT(a_emit_needs_room, i_clk, i_rst_n, o_cmd.emit_pend || o_cmd.emit_end || o_cmd.emit_ovf, $past(i_sts.out_free), "result loaded over a waiting one")

endmodule

@@ tb/sv/dest_address_flood_counter_unit_test.sv @@
// Self-checking testbench for dest_address_flood_counter_unit: per-destination
// packet counting, flood reports and table overflow, checked against a local model.
// Depends on dafc_pkg and the flood counter RTL only.
`timescale 1ns / 1ps

module dest_address_flood_counter_unit_test;
    import dafc_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int CYCLE_LIMIT  = 1000000;
    // a report walks the table entry by entry; allow for that plus slack after the last result
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 12;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
    } t_header;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  cnt;
        logic              last;
    } t_flood_result;

    // DUT ports; all inputs at known values from time zero
    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_in_valid      = 1'b0;
    logic                 o_in_ready;
    logic                 i_op            = OP_PACKET;
    logic [ADDR_W-1:0]    i_dest_addr     = '0;
    logic                 o_out_valid;
    logic                 i_out_ready     = 1'b0;
    logic [KIND_W-1:0]    o_kind;
    logic [ADDR_W-1:0]    o_flagged_addr;
    logic [CNT_W-1:0]     o_flagged_count;
    logic                 o_last;
    logic                 psel            = 1'b0;
    logic                 penable         = 1'b0;
    logic                 pwrite          = 1'b0;
    logic [PADDR_W-1:0]   paddr           = '0;
    logic [31:0]          pwdata          = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // Local copy of the counter table and the limit register
    logic [ADDR_W-1:0]    tally_addr [TABLE_DEPTH];
    logic [CNT_W-1:0]     tally_cnt  [TABLE_DEPTH];
    int                   tally_fill = 0;
    logic [CNT_W-1:0]     flood_limit = PACKET_LIMIT_RST;

    t_header              header_q[$];     // headers waiting for the driver
    t_flood_result        due_reports[$];  // results predicted, not yet seen
    int                   queued_cnt = 0;
    int                   taken_cnt  = 0;
    bit                   in_taken   = 1'b0;
    int                   fail_count = 0;
    int                   cycle_cnt  = 0;

    // Idle pressure knobs, set by the stimulus process
    int                   tx_idle_pct = 0;
    int                   rx_idle_pct = 0;
    int                   hold_asked  = 0;
    int                   hold_served = 0;
    int                   hold_left   = 0;

    dest_address_flood_counter_unit #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_dest_addr     (i_dest_addr),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_flagged_addr  (o_flagged_addr),
        .o_flagged_count (o_flagged_count),
        .o_last          (o_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Model of the table. Called once per accepted header transaction;
    // pushes whatever results that header is due to produce.
    // ------------------------------------------------------------------
    task automatic tally_header(input logic op, input logic [ADDR_W-1:0] addr);
        t_flood_result r;
        bit            found;
        int            n;
        found = 1'b0;
        n     = 0;
        if (op == OP_PACKET) begin
            // hit: bump the count, saturating at all ones
            for (int k = 0; k < tally_fill; k++) begin
                if (!found && tally_addr[k] == addr) begin
                    found = 1'b1;
                    if (tally_cnt[k] != '1)
                        tally_cnt[k] = tally_cnt[k] + 1'b1;
                end
            end
            // miss: append; reaching full depth drops the lot
            if (!found) begin
                tally_addr[tally_fill] = addr;
                tally_cnt[tally_fill]  = CNT_W'(1);
                tally_fill++;
                if (tally_fill >= TABLE_DEPTH) begin
                    tally_fill = 0;
                    r = '{kind: KIND_OVERFLOW, addr: '0, cnt: '0, last: 1'b1};
                    due_reports.push_back(r);
                end
            end
        end else begin
            // report: entries strictly above the limit, in table order
            for (int k = 0; k < tally_fill; k++) begin
                if (tally_cnt[k] > flood_limit) begin
                    r = '{kind: KIND_FLAGGED, addr: tally_addr[k], cnt: tally_cnt[k],
                          last: 1'b0};
                    due_reports.push_back(r);
                    n++;
                end
            end
            if (n == 0) begin
                r = '{kind: KIND_NONE, addr: '0, cnt: '0, last: 1'b1};
                due_reports.push_back(r);
            end else begin
                r = due_reports.pop_back();
                r.last = 1'b1;
                due_reports.push_back(r);
            end
            tally_fill = 0;
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge. Header transactions
    // feed the model, result transactions are checked against the oldest
    // prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_flood_result want;
        in_taken = i_rst_n && i_in_valid && o_in_ready;
        if (in_taken) begin
            tally_header(i_op, i_dest_addr);
            taken_cnt++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_reports.size() == 0) begin
                $display({"%0t: unexpected result, expected none, ",
                          "actual kind %0d addr %h count %h last %b"},
                         $time, o_kind, o_flagged_addr, o_flagged_count, o_last);
                fail_count++;
            end else begin
                want = due_reports.pop_front();
                check_field("kind",  32'(want.kind), 32'(o_kind));
                check_field("addr",  want.addr,      o_flagged_addr);
                check_field("count", want.cnt,       o_flagged_count);
                check_field("last",  32'(want.last), 32'(o_last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: presents headers from header_q at the falling edge. Valid is
    // held with a steady payload until the monitor has seen the transaction.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : driver
        t_header hdr;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (header_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                hdr = header_q.pop_front();
                i_in_valid  <= 1'b1;
                i_op        <= hdr.op;
                i_dest_addr <= hdr.addr;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request
    always @(negedge i_clk) begin : receiver
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_header(input logic op, input logic [ADDR_W-1:0] addr);
        t_header hdr;
        hdr.op   = op;
        hdr.addr = addr;
        header_q.push_back(hdr);
        queued_cnt++;
    endtask

    // Wait for every header to go in and every result to come out, then let
    // any result-free packet still in the pipe finish.
    task automatic settle();
        do @(negedge i_clk);
        while (taken_cnt != queued_cnt || due_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic check_limit(input logic [31:0] want_v);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= REG_PACKET_LIMIT;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        check_field("packet_limit readback", want_v, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Only called with the block idle
    task automatic write_limit(input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_PACKET_LIMIT;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        flood_limit = value;
        check_limit(value);
    endtask

    // Mostly a small set of hot destinations, so counts climb past low
    // limits; the rest random addresses and the odd report.
    task automatic queue_traffic(input int n);
        logic [ADDR_W-1:0] hot [6];
        int                pick;
        foreach (hot[k]) hot[k] = $urandom;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                queue_header(OP_REPORT, $urandom);
            else if (pick < 75)
                queue_header(OP_PACKET, hot[$urandom_range(0, 5)]);
            else
                queue_header(OP_PACKET, $urandom);
        end
    endtask

    // Run of distinct destinations, used to fill the table
    task automatic queue_run(input int n, input logic [ADDR_W-1:0] base);
        for (int k = 0; k < n; k++)
            queue_header(OP_PACKET, base + ADDR_W'(k));
    endtask

    function automatic logic [31:0] limit_plan(input int idx);
        case (idx)
            0:       return 32'd1;
            1:       return 32'd2;
            2:       return 32'd0;
            3:       return 32'd3;
            4:       return 32'd0;          // the near-full report flags every entry
            5:       return 32'hFFFF_FFFF;  // nothing can ever exceed this
            6:       return $urandom_range(0, 3);
            7:       return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 6;
        rx_idle_pct = 60;
        check_limit(PACKET_LIMIT_RST);

        // Directed: empty report, address extremes, hit and miss, reset limit
        queue_header(OP_REPORT, 32'h0000_0000);
        queue_header(OP_PACKET, 32'h0000_0000);
        queue_header(OP_PACKET, 32'hFFFF_FFFF);
        queue_header(OP_PACKET, 32'h0000_0000);
        queue_header(OP_PACKET, 32'h8000_0001);
        queue_header(OP_REPORT, 32'hFFFF_FFFF);
        settle();

        // Zero limit: every entry is flagged, last on the final one
        write_limit(32'd0);
        queue_header(OP_PACKET, 32'h1234_5678);
        queue_header(OP_PACKET, 32'hFFFF_FFFF);
        queue_header(OP_PACKET, 32'h1234_5678);
        queue_header(OP_REPORT, 32'h5555_AAAA);
        settle();

        // Limit one: only the repeated address qualifies; back-to-back
        // reports, the second on an empty table
        write_limit(32'd1);
        queue_header(OP_PACKET, 32'hA5A5_0001);
        queue_header(OP_PACKET, 32'h5A5A_0002);
        queue_header(OP_PACKET, 32'h5A5A_0002);
        queue_header(OP_REPORT, 32'h0000_0000);
        queue_header(OP_REPORT, 32'hFFFF_FFFF);
        settle();

        // All-ones limit: report with entries but none flagged
        write_limit(32'hFFFF_FFFF);
        queue_header(OP_PACKET, 32'h0000_0000);
        queue_header(OP_PACKET, 32'h0000_0000);
        queue_header(OP_REPORT, 32'h0000_0000);
        settle();

        // Random phases: sender-idle light / receiver heavy, then the reverse,
        // then no idling. Count saturation needs 2^32 hits and is left to the
        // model alone.
        for (int p = 0; p < 3; p++) begin
            tx_idle_pct = (p == 0) ? 6 : (p == 1) ? 60 : 0;
            rx_idle_pct = (p == 0) ? 60 : (p == 1) ? 6 : 0;
            for (int s = 0; s < 3; s++) begin
                settle();
                write_limit(limit_plan(p * 3 + s));
                // long receiver stall while the sender keeps offering: two
                // reports up front, the second waits on the first and the
                // input side stalls
                if (p == 0 && s == 0) begin
                    hold_asked++;
                    queue_header(OP_REPORT, $urandom);
                    queue_header(OP_REPORT, $urandom);
                end
                queue_traffic(30);
                if (s == 1) begin
                    if (p == 1) begin
                        // clear, then one short of full, then walk it all
                        queue_header(OP_REPORT, $urandom);
                        queue_run(TABLE_DEPTH - 1, $urandom);
                        queue_header(OP_REPORT, $urandom);
                    end else begin
                        queue_run(TABLE_DEPTH, $urandom);
                    end
                end
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ dest_address_flood_counter_unit.f @@
+incdir+rtl
rtl/dafc_pkg.sv
rtl/dafc_dp.sv
rtl/dafc_ctrl.sv
rtl/dest_address_flood_counter_unit.sv
tb/sv/dest_address_flood_counter_unit_test.sv
